### rtl/mncsd_pkg.sv
// Shared types and constants for the MIDI note / control change switch decoder.
package mncsd_pkg;

    // Assembler phase, one-hot
    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_DATA1  = 3'b010,
        PH_DATA2  = 3'b100
    } phase_t;

    // Kind of message being assembled
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_CTRL     = 2'd3
    } kind_t;

    // Upper nibble of the status bytes
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CTRL     = 4'hB;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_BASE_NOTE    = 1'b0;
    localparam logic REG_CC_THRESHOLD = 1'b1;

    localparam logic [6:0]  BASE_NOTE_RESET    = 7'd60;
    localparam logic [6:0]  CC_THRESHOLD_RESET = 7'd64;
    localparam logic [15:0] SWITCH_RESET       = 16'h0BB7;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int CFG_W    = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

endpackage

### rtl/midi_note_cc_switch_decoder_core.sv
// Top level: MIDI note / control change parser driving a bank of on/off switches.
//
// The block takes one MIDI byte per clock on the slave stream and sustains one
// byte per cycle while the master side is ready. Each accepted byte goes into an
// input register; from there a single stage of logic advances the
// three-byte message assembler and, when a message completes on a switch,
// loads the output register, which drives the master stream. The output
// register is the only buffer after the assembler: while a result waits there,
// the assembler stalls and the input register holds one more byte. Note On /
// Note Off for a note in the window starting at base_note, or Control Change
// with any number (taken modulo NUM_SWITCHES), sets or clears one switch; a
// message cut by a packet end is dropped.
module midi_note_cc_switch_decoder_core
    import mncsd_pkg::*;
#(
    parameter int NUM_SWITCHES = 12,
    localparam int OUT_BITS = INDEX_W + 1 + NUM_SWITCHES,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,

    // Byte stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // packet_end

    // Switch updates out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata    // [3:0] switch_index, [4] switch_on,
                                            // [4+NUM_SWITCHES:5] all_switches, rest zero
);

    // Reciprocal for modulo NUM_SWITCHES of an 8-bit byte
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + NUM_SWITCHES - 1) / NUM_SWITCHES);
    localparam int PROD_W = BYTE_W + RECIP_W;
    localparam logic [BYTE_W:0]    NUM_SW_9 = (BYTE_W+1)'(NUM_SWITCHES);
    localparam logic [BYTE_W-1:0]  NUM_SW_8 = BYTE_W'(NUM_SWITCHES);

    // Configuration registers
    logic [CFG_W-1:0] base_note_reg;
    logic [CFG_W-1:0] cc_threshold_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Assembler state
    phase_t                  phase_reg, phase_next;
    kind_t                   kind_reg, kind_next;
    logic [BYTE_W-1:0]       first_reg, first_next;
    logic [NUM_SWITCHES-1:0] switch_reg, switch_next;

    // Output register
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic proc_fire;
    logic cfg_write;
    logic result;

    logic [PROD_W-1:0]      prod;
    logic [BYTE_W-1:0]      quot;
    logic [BYTE_W-1:0]      rem_raw;
    logic [BYTE_W-1:0]      cc_index;
    logic [BYTE_W:0]        note_diff;
    logic                   note_hit;
    logic [INDEX_W-1:0]     sel_index;
    logic                   sel_on;
    logic [NUM_SWITCHES-1:0] sel_mask;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_note_reg    <= BASE_NOTE_RESET;
            cc_threshold_reg <= CC_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_BASE_NOTE)
                base_note_reg <= pwdata[CFG_W-1:0];
            else
                cc_threshold_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_CC_THRESHOLD)
            prdata = {{(APB_DW-CFG_W){1'b0}}, cc_threshold_reg};
        else
            prdata = {{(APB_DW-CFG_W){1'b0}}, base_note_reg};
    end

    // ---------------- handshakes ----------------
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ---------------- message assembler ----------------
    // Control number modulo NUM_SWITCHES: reciprocal estimate, then one correction
    assign prod     = PROD_W'(first_reg) * PROD_W'(RECIP);
    assign quot     = prod[RECIP_SHIFT +: BYTE_W];
    assign rem_raw  = first_reg - BYTE_W'(quot * NUM_SW_8);
    assign cc_index = (rem_raw >= NUM_SW_8) ? (rem_raw - NUM_SW_8) : rem_raw;

    assign note_diff = {1'b0, first_reg} - {2'b00, base_note_reg};
    assign note_hit  = !note_diff[BYTE_W] && (note_diff < NUM_SW_9);

    always_comb
    begin
        if (kind_reg == KIND_CTRL)
        begin
            sel_index = cc_index[INDEX_W-1:0];
            sel_on    = in_byte_reg > {1'b0, cc_threshold_reg};
        end
        else
        begin
            sel_index = note_diff[INDEX_W-1:0];
            sel_on    = (kind_reg == KIND_NOTE_ON) && (in_byte_reg != '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SWITCHES; i++)
            sel_mask[i] = (sel_index == INDEX_W'(i));
    end

    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        first_next    = first_reg;
        switch_next   = switch_reg;
        result        = 1'b0;

        case (phase_reg)
            PH_DATA1:
            begin
                first_next = in_byte_reg;
                phase_next = PH_DATA2;
            end
            PH_DATA2:
            begin
                phase_next = PH_STATUS;
                if ((kind_reg == KIND_CTRL) || note_hit)
                begin
                    result      = 1'b1;
                    switch_next = sel_on ? (switch_reg | sel_mask) : (switch_reg & ~sel_mask);
                end
            end
            default:
            begin
                phase_next = PH_STATUS;
                case (in_byte_reg[7:4])
                    STAT_NOTE_ON:
                    begin
                        kind_next  = KIND_NOTE_ON;
                        phase_next = PH_DATA1;
                    end
                    STAT_NOTE_OFF:
                    begin
                        kind_next  = KIND_NOTE_OFF;
                        phase_next = PH_DATA1;
                    end
                    STAT_CTRL:
                    begin
                        kind_next  = KIND_CTRL;
                        phase_next = PH_DATA1;
                    end
                    default:
                    begin
                        kind_next = kind_reg;
                    end
                endcase
            end
        endcase

        // Drop any partial message at packet end
        if (in_last_reg)
            phase_next = PH_STATUS;

        out_data_next = '0;
        out_data_next[INDEX_W-1:0]             = sel_index;
        out_data_next[INDEX_W]                 = sel_on;
        out_data_next[INDEX_W+1 +: NUM_SWITCHES] = switch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            kind_reg   <= KIND_NONE;
            first_reg  <= '0;
            switch_reg <= SWITCH_RESET[NUM_SWITCHES-1:0];
        end
        else if (proc_fire)
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            first_reg  <= first_next;
            switch_reg <= switch_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && result)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && result)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
